### src/rthc_pkg.sv
// shared types and constants of the rtp receive header classifier
package rthc_pkg;

	// field widths
	localparam int unsigned TS_W    = 32;
	localparam int unsigned SID_W   = 32;
	localparam int unsigned PT_W    = 7;
	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned EXT_W   = 16;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned BUF_W   = 16;
	localparam int unsigned SUB_W   = 3;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned RATE_W  = 8;
	localparam int unsigned CFG_AW  = 3;
	localparam int unsigned CFG_DW  = 8;

	// stream bus widths, padded to whole bytes
	localparam int unsigned S_DATA_W = 136;
	localparam int unsigned S_USER_W = 8;
	localparam int unsigned M_DATA_W = 120;
	localparam int unsigned M_USER_W = 8;

	// divider step counter
	localparam int unsigned DIV_CNT_W = $clog2(TS_W);

	// media kinds
	localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;

	// result subtypes
	localparam logic [SUB_W-1:0] SUB_REFRESH  = 3'd0;
	localparam logic [SUB_W-1:0] SUB_PAYLOAD  = 3'd1;
	localparam logic [SUB_W-1:0] SUB_ROT0     = 3'd2;
	localparam logic [SUB_W-1:0] SUB_T140     = 3'd6;
	localparam logic [SUB_W-1:0] SUB_T140_RED = 3'd7;

	// configuration register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_MEDIA_KIND    = 3'd0,
		REG_SAMPLING_KHZ  = 3'd1,
		REG_ROTATION_EN   = 3'd2,
		REG_PRIMARY_PT    = 3'd3,
		REG_REDUNDANT_PT  = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_REFRESH,
		ST_PAYLOAD
	} state_t;

	// divider control from the sequencer
	typedef struct packed {
		logic load;
		logic run;
	} div_ctrl_t;

endpackage

### src/rthc_div.sv
// bit-serial restoring divider: 32-bit timestamp by 8-bit rate, one quotient bit per cycle
module rthc_div
	import rthc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctrl_t         ctrl,
	input  logic [TS_W-1:0]   dividend,
	input  logic [RATE_W-1:0] divisor,
	output logic              busy,
	output logic [TS_W-1:0]   quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]      work_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W:0]      trial;
	logic [RATE_W:0]      diff;
	logic                 fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, work_q[TS_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	// control: step count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= ctrl.run;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(TS_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[TS_W-2:0], fits};
			rem_q  <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q;

endmodule

### src/rtp_receive_header_classifier_top.sv
// top level of the rtp receive header classifier: config, sequencer, state and output register
//
// Usage:
// - Input channel s_axis: one decoded rtp header per transaction. s_axis_tready is high only
//   while the block is idle; one header is worked on at a time.
// - Output channel m_axis: one or two results per header. When the ssrc changes, a refresh
//   result (tlast low) comes first, then the payload result (tlast high).
// - Timestamp scaling (non-video kinds with a nonzero rate) runs in a bit-serial divider
//   of 32 steps, one quotient bit per cycle.
// - Each result waits in the output register until taken.
// - When the receiver stalls, the result holds in the output register and no new header is
//   accepted until the payload result is taken.
// - Reset clears the config registers, the stored ssrc to zero and the sticky subtype to
//   plain payload; no result is pending afterwards.
// - Configuration is written through cfg_we / cfg_addr / cfg_data while the block is idle.
module rtp_receive_header_classifier_top
	import rthc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// config write port
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_DW-1:0]   cfg_data,
	// input headers
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// rtp_timestamp, source_id, marker_in, sequence_in, has_extension, extension_word,
	// length_in, buffer_ref_in, zero pad
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// payload_type, zero pad
	input  logic [S_USER_W-1:0] s_axis_tuser,
	// results
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// new_source_id, time_out, marker_out, sequence_out, length_out, buffer_ref_out, zero pad
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// subtype_code, zero pad
	output logic [M_USER_W-1:0] m_axis_tuser,
	// last_of_run
	output logic                m_axis_tlast
);

	// unpacked input fields
	logic [TS_W-1:0]  in_ts;
	logic [SID_W-1:0] in_sid;
	logic [PT_W-1:0]  in_pt;
	logic             in_mark;
	logic [SEQ_W-1:0] in_seq;
	logic             in_has_ext;
	logic [EXT_W-1:0] in_ext;
	logic [LEN_W-1:0] in_len;
	logic [BUF_W-1:0] in_buf;

	assign in_ts      = s_axis_tdata[31:0];
	assign in_sid     = s_axis_tdata[63:32];
	assign in_mark    = s_axis_tdata[64];
	assign in_seq     = s_axis_tdata[80:65];
	assign in_has_ext = s_axis_tdata[81];
	assign in_ext     = s_axis_tdata[97:82];
	assign in_len     = s_axis_tdata[113:98];
	assign in_buf     = s_axis_tdata[129:114];
	assign in_pt      = s_axis_tuser[PT_W-1:0];

	// config registers
	logic [KIND_W-1:0] kind_q;
	logic [RATE_W-1:0] rate_q;
	logic              rot_en_q;
	logic [PT_W-1:0]   prim_pt_q;
	logic [PT_W-1:0]   red_pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= '0;
			rate_q    <= '0;
			rot_en_q  <= 1'b0;
			prim_pt_q <= '0;
			red_pt_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MEDIA_KIND:   kind_q    <= cfg_data[KIND_W-1:0];
				REG_SAMPLING_KHZ: rate_q    <= cfg_data[RATE_W-1:0];
				REG_ROTATION_EN:  rot_en_q  <= cfg_data[0];
				REG_PRIMARY_PT:   prim_pt_q <= cfg_data[PT_W-1:0];
				REG_REDUNDANT_PT: red_pt_q  <= cfg_data[PT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state
	state_t    state_q;
	state_t    state_d;
	logic      in_acc;
	logic      load_refresh;
	logic      load_payload;
	logic      div_busy;
	logic      refresh_q;
	div_ctrl_t div_ctrl;
	logic [TS_W-1:0] quotient;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// divider loads on every accepted header, runs only when scaling applies
	assign div_ctrl.load = in_acc;
	assign div_ctrl.run  = (kind_q != KIND_VIDEO) && (rate_q != '0);

	rthc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (in_ts),
		.divisor  (rate_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) state_d = refresh_q ? ST_REFRESH : ST_PAYLOAD;
			end
			ST_REFRESH: begin
				if (m_axis_tready) state_d = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load_refresh  = 1'b0;
		load_payload  = 1'b0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_DIV: begin
				load_refresh = !div_busy && refresh_q;
				load_payload = !div_busy && !refresh_q;
			end
			ST_REFRESH: begin
				m_axis_tvalid = 1'b1;
				load_payload  = m_axis_tready;
			end
			ST_PAYLOAD: m_axis_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// subtype update for the accepted header
	logic [SUB_W-1:0] sticky_q;
	logic [SUB_W-1:0] sticky_d;
	logic [SID_W-1:0] cur_sid_q;

	always_comb begin
		sticky_d = sticky_q;
		if (in_has_ext && kind_q == KIND_VIDEO && rot_en_q) begin
			sticky_d = SUB_ROT0 + {1'b0, in_ext[1:0]};
		end
		if (kind_q == KIND_TEXT) begin
			priority if (in_pt == prim_pt_q) begin
				sticky_d = (red_pt_q == '0) ? SUB_T140 : SUB_T140_RED;
			end else if (in_pt == red_pt_q) begin
				sticky_d = SUB_T140;
			end else begin
				// unknown text payload type keeps the previous subtype
				sticky_d = sticky_q;
			end
		end
	end

	// stream state: stored ssrc, sticky subtype, refresh flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sid_q <= '0;
			sticky_q  <= SUB_PAYLOAD;
			refresh_q <= 1'b0;
		end else if (in_acc) begin
			cur_sid_q <= in_sid;
			sticky_q  <= sticky_d;
			refresh_q <= in_sid != cur_sid_q;
		end
	end

	// header fields held while the divider runs
	logic             mark_q;
	logic [SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0] len_q;
	logic [BUF_W-1:0] buf_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mark_q <= in_mark;
			seq_q  <= in_seq;
			len_q  <= in_len;
			buf_q  <= in_buf;
		end
	end

	// output register
	logic [SUB_W-1:0] o_sub_q;
	logic [SID_W-1:0] o_sid_q;
	logic [TS_W-1:0]  o_ts_q;
	logic             o_mark_q;
	logic [SEQ_W-1:0] o_seq_q;
	logic [LEN_W-1:0] o_len_q;
	logic [BUF_W-1:0] o_buf_q;
	logic             o_last_q;

	always_ff @(posedge clk) begin
		if (load_refresh) begin
			o_sub_q  <= SUB_REFRESH;
			o_sid_q  <= cur_sid_q;
			o_ts_q   <= '0;
			o_mark_q <= 1'b0;
			o_seq_q  <= '0;
			o_len_q  <= '0;
			o_buf_q  <= '0;
			o_last_q <= 1'b0;
		end else if (load_payload) begin
			o_sub_q  <= sticky_q;
			o_sid_q  <= '0;
			o_ts_q   <= quotient;
			o_mark_q <= mark_q;
			o_seq_q  <= seq_q;
			o_len_q  <= len_q;
			o_buf_q  <= buf_q;
			o_last_q <= 1'b1;
		end
	end

	assign m_axis_tdata = {7'd0, o_buf_q, o_len_q, o_seq_q, o_mark_q, o_ts_q, o_sid_q};
	assign m_axis_tuser = {(M_USER_W - SUB_W)'(0), o_sub_q};
	assign m_axis_tlast = o_last_q;

	// checks
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("header accepted while another is in flight");

	a_ready_excludes_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result is pending");

	a_refresh_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REFRESH) |-> (!m_axis_tlast && m_axis_tuser[SUB_W-1:0] == SUB_REFRESH))
		else $error("refresh result carries wrong subtype or tlast");

	a_payload_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAYLOAD) |-> m_axis_tlast)
		else $error("payload result without tlast");

	a_div_done_before_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !div_busy)
		else $error("result shown while the divider is still running");

endmodule
